// ===== src/imfe_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and tables of the metropolis flip engine
// no dependencies
package imfe_pkg;

	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;

	localparam int J_W   = 16;  // coupling width, signed q8.8
	localparam int B_W   = 16;  // inverse temperature, unsigned q8.8
	localparam int DIM_W = 7;   // rows_used / cols_used
	localparam int SITE_W = 6;
	localparam int CNT_W = 10;  // uniform draw
	localparam int H_W   = 19;  // local field sum
	localparam int DE_W  = 20;  // energy change
	localparam int E_W   = 30;  // energy total
	localparam int M_W   = 14;  // spin total
	localparam int P_W   = 17;  // probability q0.16, up to 1.0

	localparam logic [16:0] LOG2E_Q16  = 17'd94548;
	localparam logic [9:0]  PROB_SCALE = 10'd1000;

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_FLIP   = 2'd1,
		KIND_RECALC = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CFG_ROW   = 3'd0,
		CFG_NEAR  = 3'd1,
		CFG_FAR   = 3'd2,
		CFG_BETA  = 3'd3,
		CFG_TORUS = 3'd4,
		CFG_ROWS  = 3'd5,
		CFG_COLS  = 3'd6
	} cfg_idx_t;

	// neighbor codes, order of the flip read sequence
	typedef enum logic [2:0] {
		NB_SELF  = 3'd0,
		NB_LEFT  = 3'd1,
		NB_RIGHT = 3'd2,
		NB_UP    = 3'd3,
		NB_DOWN  = 3'd4,
		NB_UP2   = 3'd5,
		NB_DOWN2 = 3'd6
	} nbr_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FRD,
		S_FWAIT,
		S_FDE,
		S_FCHK,
		S_FEXP,
		S_FUPD,
		S_WALK,
		S_WWAIT,
		S_WEND,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DE_W-2:0]  de;
		logic [B_W-1:0]   beta;
		logic [CNT_W-1:0] count;
	} exp_req_t;

	typedef struct packed {
		logic done;
		logic take;
	} exp_rsp_t;

	// round(65536 * 2^(-i/16))
	function automatic logic [P_W-1:0] pow2_neg(input logic [4:0] i);
		logic [P_W-1:0] v;
		case (i)
			5'd0:    v = 17'd65536;
			5'd1:    v = 17'd62757;
			5'd2:    v = 17'd60097;
			5'd3:    v = 17'd57549;
			5'd4:    v = 17'd55109;
			5'd5:    v = 17'd52773;
			5'd6:    v = 17'd50535;
			5'd7:    v = 17'd48393;
			5'd8:    v = 17'd46341;
			5'd9:    v = 17'd44376;
			5'd10:   v = 17'd42495;
			5'd11:   v = 17'd40693;
			5'd12:   v = 17'd38968;
			5'd13:   v = 17'd37316;
			5'd14:   v = 17'd35734;
			5'd15:   v = 17'd34219;
			5'd16:   v = 17'd32768;
			default: v = 17'd32768;
		endcase
		return v;
	endfunction

endpackage

// ===== src/imfe_spin_mem.sv =====
`timescale 1ns / 1ps
// one-bit spin store, one write port and one registered read port
// no package dependencies
module imfe_spin_mem #(
	parameter int AW = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	localparam int DEPTH = 1 << AW;

	logic mem_q [DEPTH];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/imfe_exp_unit.sv =====
`timescale 1ns / 1ps
// multi-cycle acceptance test: p = exp(-de*beta) in q0.16, take = u < p
// depends on imfe_pkg
module imfe_exp_unit
	import imfe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  exp_req_t req,
	output exp_rsp_t rsp
);

	localparam logic [2:0] LAST_STEP = 3'd6;

	logic             busy_q;
	logic [2:0]       step_q;
	logic [DE_W-2:0]  de_q;
	logic [B_W-1:0]   beta_q;
	logic [CNT_W-1:0] count_q;
	logic [34:0]      x_q;
	logic [34:0]      pl_q;
	logic [33:0]      ph_q;
	logic             zero_q;
	logic [4:0]       k_q;
	logic [3:0]       idx_q;
	logic [11:0]      frac_q;
	logic [P_W-1:0]   m_q;
	logic [26:0]      pk_q;

	logic [51:0]    prod;
	logic [P_W-1:0] t0, t1, m_d, p_d;
	logic [11:0]    dlt;
	logic [23:0]    slope;

	always_comb begin
		prod  = {ph_q, 18'b0} + {17'b0, pl_q};
		t0    = pow2_neg({1'b0, idx_q});
		t1    = pow2_neg({1'b0, idx_q} + 5'd1);
		dlt   = 12'(t0 - t1);
		slope = {12'b0, dlt} * {12'b0, frac_q};
		m_d   = t0 - {5'b0, slope[23:12]};
		p_d   = zero_q ? '0 : (m_q >> k_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (!busy_q) begin
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end
		end else begin
			step_q <= step_q + 3'd1;
			if (step_q == LAST_STEP) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && req.start) begin
			de_q    <= req.de;
			beta_q  <= req.beta;
			count_q <= req.count;
		end
		if (busy_q) begin
			case (step_q)
				3'd0: x_q  <= {16'b0, de_q} * {19'b0, beta_q};
				3'd1: pl_q <= {17'b0, x_q[17:0]} * {18'b0, LOG2E_Q16};
				3'd2: ph_q <= {17'b0, x_q[34:18]} * {17'b0, LOG2E_Q16};
				3'd3: begin
					// integer part of x*log2(e) above 16 leaves nothing
					zero_q <= (prod[51:32] > 20'd16);
					k_q    <= prod[36:32];
					idx_q  <= prod[31:28];
					frac_q <= prod[27:16];
				end
				3'd4: m_q  <= m_d;
				3'd5: pk_q <= {10'b0, p_d} * {17'b0, PROB_SCALE};
				default: ;
			endcase
		end
	end

	assign rsp.done = busy_q && (step_q == LAST_STEP);
	assign rsp.take = {1'b0, count_q, 16'b0} < pk_q;

endmodule

// ===== src/ising_metropolis_flip_engine_unit.sv =====
`timescale 1ns / 1ps
// top level of the metropolis flip engine: config registers, sequencer, totals
// depends on imfe_pkg, imfe_spin_mem, imfe_exp_unit
//
//  channel   direction  handshake            payload
//  in        to block   in_valid / in_stall  kind, site_row, site_col, spin_value,
//                                            uniform_count
//  out       from block out_valid/out_stall  accepted, delta_energy, energy_total,
//                                            spin_total
//  cfg       to block   cfg_we               cfg_index, cfg_data
//
// load, unused kinds and a flip outside the lattice go straight to the done state; a flip
// inside makes seven spin reads through the single memory read port, then uses
// the 7-step exponential unit when de >= 0
// recompute makes four reads per site through the same port
// reset clears totals and control and sets config to its defaults; the spin store is not cleared
// a new word is taken while a finished word waits on a stalled output; the next
// result waits in the done state until the output register frees
module ising_metropolis_flip_engine_unit
	import imfe_pkg::*;
#(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               kind,
	input  logic [SITE_W-1:0]        site_row,
	input  logic [SITE_W-1:0]        site_col,
	input  logic                     spin_value,
	input  logic [CNT_W-1:0]         uniform_count,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     accepted,
	output logic signed [DE_W-1:0]   delta_energy,
	output logic signed [E_W-1:0]    energy_total,
	output logic signed [M_W-1:0]    spin_total,
	input  logic                     cfg_we,
	input  logic [2:0]               cfg_index,
	input  logic [J_W-1:0]           cfg_data
);

	localparam int RI = $clog2(MAX_ROWS);
	localparam int CI = $clog2(MAX_COLS);
	// row and column arithmetic wide enough for r+2 and for rows_used
	localparam int RA = (RI + 2 > DIM_W + 1) ? RI + 2 : DIM_W + 1;
	localparam int CA = (CI + 2 > DIM_W + 1) ? CI + 2 : DIM_W + 1;
	localparam int AW = RI + CI;
	localparam logic [M_W-1:0] MAG_STEP = M_W'(2);

	// configuration registers
	logic signed [J_W-1:0] j0_q, j1_q, j2_q;
	logic [B_W-1:0]        beta_q;
	logic                  torus_q;
	logic [DIM_W-1:0]      rows_q, cols_q;

	// sequencer and working registers
	state_t              state_d;
	state_t              state_q;
	nbr_t                nb_q;
	logic [1:0]          sub_q;
	logic [RA-1:0]       r_q;
	logic [CA-1:0]       c_q;
	logic [CNT_W-1:0]    count_q;
	logic                self_q;
	logic signed [H_W-1:0]  h_q;
	logic signed [DE_W-1:0] de_q;
	logic                take_q;
	logic signed [E_W-1:0]  energy_q, re_q;
	logic signed [M_W-1:0]  mag_q, rm_q;

	// read pipeline stage
	logic  vld_s1, walk_s1, pres_s1;
	nbr_t  code_s1;

	// output register
	logic                   out_valid_q;
	logic                   accepted_q;
	logic signed [DE_W-1:0] delta_q;
	logic signed [E_W-1:0]  energy_out_q;
	logic signed [M_W-1:0]  spin_out_q;

	logic          in_acc, out_free, flip_ok, load_ok, walk_last;
	logic [RA-1:0] dim_r, rows_ext, row_in;
	logic [CA-1:0] dim_c, cols_ext, col_in;
	nbr_t          code;
	logic [RA-1:0] nr, rt;
	logic [CA-1:0] nc;
	logic          pres, rd_go;
	logic [AW-1:0] raddr, waddr;
	logic          we, wdata, rdata;
	logic signed [H_W-1:0]  jsel, term, hn;
	logic signed [DE_W-1:0] de_d;
	exp_req_t      exp_req;
	exp_rsp_t      exp_rsp;

	// effective lattice size: zero acts as one, oversize clamps
	always_comb begin
		rows_ext = RA'(rows_q);
		cols_ext = CA'(cols_q);
		if (rows_q == '0)
			dim_r = RA'(1);
		else if (rows_ext > RA'(MAX_ROWS))
			dim_r = RA'(MAX_ROWS);
		else
			dim_r = rows_ext;
		if (cols_q == '0)
			dim_c = CA'(1);
		else if (cols_ext > CA'(MAX_COLS))
			dim_c = CA'(MAX_COLS);
		else
			dim_c = cols_ext;
	end

	assign row_in  = RA'(site_row);
	assign col_in  = CA'(site_col);
	assign flip_ok = (row_in < dim_r) && (col_in < dim_c);
	assign load_ok = (row_in < RA'(MAX_ROWS)) && (col_in < CA'(MAX_COLS));
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign walk_last = (sub_q == 2'd3) && (r_q == dim_r - RA'(1)) && (c_q == dim_c - CA'(1));

	// which neighbor the read port fetches this cycle; the walk reads
	// self, right, down and down-two of each site
	always_comb begin
		if (state_q == S_WALK) begin
			case (sub_q)
				2'd0:    code = NB_SELF;
				2'd1:    code = NB_RIGHT;
				2'd2:    code = NB_DOWN;
				default: code = NB_DOWN2;
			endcase
		end else begin
			code = nb_q;
		end
	end

	// neighbor coordinates; pres low for a missing partner at an open edge
	always_comb begin
		nr   = r_q;
		nc   = c_q;
		pres = 1'b1;
		rt   = r_q + RA'(2) - dim_r;
		unique case (code)
			NB_SELF: ;
			NB_LEFT: begin
				if (c_q != '0) begin
					nc = c_q - CA'(1);
				end else begin
					nc   = dim_c - CA'(1);
					pres = torus_q;
				end
			end
			NB_RIGHT: begin
				if (c_q + CA'(1) < dim_c) begin
					nc = c_q + CA'(1);
				end else begin
					nc   = c_q + CA'(1) - dim_c;
					pres = torus_q;
				end
			end
			NB_UP: begin
				if (r_q != '0) begin
					nr = r_q - RA'(1);
				end else begin
					nr   = dim_r - RA'(1);
					pres = torus_q;
				end
			end
			NB_DOWN: begin
				if (r_q + RA'(1) < dim_r) begin
					nr = r_q + RA'(1);
				end else begin
					nr   = r_q + RA'(1) - dim_r;
					pres = torus_q;
				end
			end
			NB_UP2: begin
				if (r_q >= RA'(2)) begin
					nr = r_q - RA'(2);
				end else begin
					nr   = (dim_r == RA'(1)) ? '0 : r_q + dim_r - RA'(2);
					pres = torus_q;
				end
			end
			NB_DOWN2: begin
				if (r_q + RA'(2) < dim_r) begin
					nr = r_q + RA'(2);
				end else begin
					// a one-row torus wraps twice
					nr   = (rt < dim_r) ? rt : rt - dim_r;
					pres = torus_q;
				end
			end
			default: ;
		endcase
	end

	assign rd_go = (state_q == S_FRD) || (state_q == S_WALK);
	assign raddr = {nr[RI-1:0], nc[CI-1:0]};

	// write port: load at accept, or the flip itself
	always_comb begin
		if (state_q == S_FUPD) begin
			we    = take_q;
			waddr = {r_q[RI-1:0], c_q[CI-1:0]};
			wdata = !self_q;
		end else begin
			we    = in_acc && (kind == KIND_LOAD) && load_ok;
			waddr = {row_in[RI-1:0], col_in[CI-1:0]};
			wdata = spin_value;
		end
	end

	imfe_spin_mem #(
		.AW(AW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// contribution of the returning spin
	always_comb begin
		case (code_s1)
			NB_LEFT, NB_RIGHT: jsel = H_W'(j0_q);
			NB_UP, NB_DOWN:    jsel = H_W'(j1_q);
			default:           jsel = H_W'(j2_q);
		endcase
		if (!pres_s1)
			term = '0;
		else if (rdata)
			term = jsel;
		else
			term = -jsel;
		hn   = h_q + term;
		de_d = self_q ? {h_q, 1'b0} : -{h_q, 1'b0};
	end

	assign exp_req.start = (state_q == S_FCHK) && !de_q[DE_W-1];
	assign exp_req.de    = de_q[DE_W-2:0];
	assign exp_req.beta  = beta_q;
	assign exp_req.count = count_q;

	imfe_exp_unit u_exp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (exp_req),
		.rsp    (exp_rsp)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (kind)
						KIND_FLIP:   state_d = flip_ok ? S_FRD : S_DONE;
						KIND_RECALC: state_d = S_WALK;
						default:     state_d = S_DONE;
					endcase
				end
			end
			S_FRD:   if (nb_q == NB_DOWN2) state_d = S_FWAIT;
			S_FWAIT: state_d = S_FDE;
			S_FDE:   state_d = S_FCHK;
			S_FCHK:  state_d = de_q[DE_W-1] ? S_FUPD : S_FEXP;
			S_FEXP:  if (exp_rsp.done) state_d = S_FUPD;
			S_FUPD:  state_d = S_DONE;
			S_WALK:  if (walk_last) state_d = S_WWAIT;
			S_WWAIT: state_d = S_WEND;
			S_WEND:  state_d = S_DONE;
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j0_q    <= 16'sd256;
			j1_q    <= 16'sd256;
			j2_q    <= '0;
			beta_q  <= 16'd51;
			torus_q <= 1'b1;
			rows_q  <= 7'd32;
			cols_q  <= 7'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROW:   j0_q    <= cfg_data;
				CFG_NEAR:  j1_q    <= cfg_data;
				CFG_FAR:   j2_q    <= cfg_data;
				CFG_BETA:  beta_q  <= cfg_data;
				CFG_TORUS: torus_q <= cfg_data[0];
				CFG_ROWS:  rows_q  <= cfg_data[DIM_W-1:0];
				CFG_COLS:  cols_q  <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// totals, walk and flip read position, read pipeline valid and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q    <= '0;
			mag_q       <= '0;
			r_q         <= '0;
			c_q         <= '0;
			sub_q       <= '0;
			nb_q        <= NB_SELF;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= rd_go;
			if (in_acc) begin
				nb_q  <= NB_SELF;
				sub_q <= '0;
				if (kind == KIND_RECALC) begin
					r_q <= '0;
					c_q <= '0;
				end else begin
					r_q <= row_in;
					c_q <= col_in;
				end
			end
			if (state_q == S_FRD) begin
				nb_q <= nbr_t'(nb_q + 3'd1);
			end
			// walk: four reads per site, row-major
			if (state_q == S_WALK) begin
				sub_q <= sub_q + 2'd1;
				if (sub_q == 2'd3 && !walk_last) begin
					if (c_q == dim_c - CA'(1)) begin
						c_q <= '0;
						r_q <= r_q + RA'(1);
					end else begin
						c_q <= c_q + CA'(1);
					end
				end
			end
			if (state_q == S_FUPD && take_q) begin
				energy_q <= energy_q + E_W'(de_q);
				mag_q    <= self_q ? mag_q - MAG_STEP : mag_q + MAG_STEP;
			end
			if (state_q == S_WEND) begin
				energy_q <= re_q;
				mag_q    <= rm_q;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		code_s1 <= code;
		pres_s1 <= pres;
		walk_s1 <= (state_q == S_WALK);
		if (in_acc) begin
			count_q <= uniform_count;
			take_q  <= 1'b0;
			de_q    <= '0;
			re_q    <= '0;
			rm_q    <= '0;
		end
		if (vld_s1) begin
			if (code_s1 == NB_SELF) begin
				self_q <= rdata;
				h_q    <= '0;
			end else begin
				h_q <= hn;
			end
			// last bond of a site closes its energy and spin terms
			if (walk_s1 && code_s1 == NB_DOWN2) begin
				re_q <= self_q ? re_q - E_W'(hn) : re_q + E_W'(hn);
				rm_q <= self_q ? rm_q + M_W'(1) : rm_q - M_W'(1);
			end
		end
		if (state_q == S_FDE) begin
			de_q <= de_d;
		end
		if (state_q == S_FCHK && de_q[DE_W-1]) begin
			take_q <= 1'b1;
		end
		if (state_q == S_FEXP && exp_rsp.done) begin
			take_q <= exp_rsp.take;
		end
		if (state_q == S_DONE && out_free) begin
			accepted_q   <= take_q;
			delta_q      <= de_q;
			energy_out_q <= energy_q;
			spin_out_q   <= mag_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign accepted     = accepted_q;
	assign delta_energy = delta_q;
	assign energy_total = energy_out_q;
	assign spin_total   = spin_out_q;

	// exponential result only lands while the sequencer waits for it
	a_exp_done: assert property (@(posedge clk) disable iff (!arst_n)
		exp_rsp.done |-> state_q == S_FEXP)
		else $error("exp unit finished outside the wait state");

	// the store is written only by a load at accept or by a flip update
	a_mem_write: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_IDLE || state_q == S_FUPD))
		else $error("spin store written out of sequence");

	// an accepted word always leaves idle
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != S_IDLE)
		else $error("accepted word did not start work");

	// the walk stays inside the used lattice
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> (r_q < dim_r && c_q < dim_c))
		else $error("walk position out of lattice");

	// a flip update that takes the flip is followed by the done state
	a_take_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FUPD && take_q) |=> state_q == S_DONE)
		else $error("flip update did not finish");

endmodule

// ===== dv/imfe_flip_checker.sv =====
`timescale 1ns / 1ps
// scoreboard of the metropolis flip engine: predicts each result word and compares
// depends on imfe_pkg
module imfe_flip_checker
	import imfe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [1:0]        kind,
	input  logic [SITE_W-1:0] site_row,
	input  logic [SITE_W-1:0] site_col,
	input  logic              spin_value,
	input  logic [CNT_W-1:0]  uniform_count,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              accepted,
	input  logic [DE_W-1:0]   delta_energy,
	input  logic [E_W-1:0]    energy_total,
	input  logic [M_W-1:0]    spin_total,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [J_W-1:0]    cfg_data,
	output int                fails,
	output int                pending
);

	typedef struct {
		logic            acc;
		logic [DE_W-1:0] de;
		logic [E_W-1:0]  energy;
		logic [M_W-1:0]  mag;
	} step_result_t;

	step_result_t result_q[$];

	bit          lattice [0:4095];
	logic [E_W-1:0] energy;
	logic [M_W-1:0] mag;
	logic [15:0] j_row, j_near, j_far, beta;
	logic        torus;
	logic [6:0]  rows_raw, cols_raw;

	function automatic int eff_dim(input logic [6:0] v);
		if (v == 0) return 1;
		if (v > 64) return 64;
		return int'(v);
	endfunction

	function automatic longint spin_of(input int r, input int c);
		return lattice[r * 64 + c] ? 64'sd1 : -64'sd1;
	endfunction

	function automatic longint unsigned exp2_neg_tab(input int i);
		case (i)
			0: return 65536;   1: return 62757;   2: return 60097;   3: return 57549;
			4: return 55109;   5: return 52773;   6: return 50535;   7: return 48393;
			8: return 46341;   9: return 44376;  10: return 42495;  11: return 40693;
			12: return 38968; 13: return 37316;  14: return 35734;  15: return 34219;
			default: return 32768;
		endcase
	endfunction

	// q0.16 estimate of exp(-x), x in q16.16
	function automatic longint unsigned boltzmann_q16(input longint unsigned x);
		longint unsigned y, k, f, i, fr, m;
		y = (x * 64'd94548) >> 16;
		k = y >> 16;
		f = y & 64'hFFFF;
		i = f >> 12;
		fr = f & 64'hFFF;
		if (k > 16) return 0;
		m = exp2_neg_tab(int'(i))
			- (((exp2_neg_tab(int'(i)) - exp2_neg_tab(int'(i) + 1)) * fr) >> 12);
		return m >> k;
	endfunction

	task automatic rebuild_totals();
		int nr, nc, r, c;
		longint a, b, g, s, h, e, mg;
		nr = eff_dim(rows_raw);
		nc = eff_dim(cols_raw);
		a = longint'($signed(j_row));
		b = longint'($signed(j_near));
		g = longint'($signed(j_far));
		e = 0;
		mg = 0;
		for (int idx = 0; idx < nr * nc; idx++) begin
			r = idx / nc;
			c = idx % nc;
			s = spin_of(r, c);
			h = 0;
			if (torus) begin
				h = a * spin_of(r, (c + 1) % nc) + b * spin_of((r + 1) % nr, c)
					+ g * spin_of((r + 2) % nr, c);
			end else begin
				if (c + 1 < nc) h += a * spin_of(r, c + 1);
				if (r + 1 < nr) h += b * spin_of(r + 1, c);
				if (r + 2 < nr) h += g * spin_of(r + 2, c);
			end
			e -= s * h;
			mg += s;
		end
		energy = e[E_W-1:0];
		mag = mg[M_W-1:0];
	endtask

	task automatic predict_word();
		step_result_t res;
		int nr, nc, r, c;
		longint a, b, g, s, h, de;
		bit take;
		res.acc = 1'b0;
		res.de = '0;
		r = int'(site_row);
		c = int'(site_col);
		case (kind)
			KIND_LOAD: lattice[r * 64 + c] = spin_value;
			KIND_RECALC: rebuild_totals();
			KIND_FLIP: begin
				nr = eff_dim(rows_raw);
				nc = eff_dim(cols_raw);
				if (r < nr && c < nc) begin
					a = longint'($signed(j_row));
					b = longint'($signed(j_near));
					g = longint'($signed(j_far));
					s = spin_of(r, c);
					h = 0;
					if (torus) begin
						h = a * (spin_of(r, (c + nc - 1) % nc) + spin_of(r, (c + 1) % nc))
							+ b * (spin_of((r + nr - 1) % nr, c) + spin_of((r + 1) % nr, c))
							+ g * (spin_of((r + 2 * nr - 2) % nr, c) + spin_of((r + 2) % nr, c));
					end else begin
						if (c != 0) h += a * spin_of(r, c - 1);
						if (c + 1 < nc) h += a * spin_of(r, c + 1);
						if (r >= 1) h += b * spin_of(r - 1, c);
						if (r + 1 < nr) h += b * spin_of(r + 1, c);
						if (r >= 2) h += g * spin_of(r - 2, c);
						if (r + 2 < nr) h += g * spin_of(r + 2, c);
					end
					de = 2 * s * h;
					if (de < 0)
						take = 1'b1;
					else
						take = (longint'(uniform_count) << 16)
							< boltzmann_q16(longint'(de) * longint'(beta)) * 1000;
					if (take) begin
						lattice[r * 64 + c] = (s > 0) ? 1'b0 : 1'b1;
						energy = energy + de[E_W-1:0];
						mag = (s > 0) ? mag - 14'd2 : mag + 14'd2;
						res.acc = 1'b1;
					end
					res.de = de[DE_W-1:0];
				end
			end
			default: ;
		endcase
		res.energy = energy;
		res.mag = mag;
		result_q.push_back(res);
	endtask

	task automatic check_word();
		step_result_t want;
		if (result_q.size() == 0) begin
			$display("%0t: result word with nothing expected", $realtime);
			fails++;
			return;
		end
		want = result_q.pop_front();
		if (accepted !== want.acc) begin
			$display("%0t: accepted exp %0d got %0d", $realtime, want.acc, accepted);
			fails++;
		end
		if (delta_energy !== want.de) begin
			$display("%0t: delta_energy exp %0d got %0d", $realtime,
				$signed(want.de), $signed(delta_energy));
			fails++;
		end
		if (energy_total !== want.energy) begin
			$display("%0t: energy_total exp %0d got %0d", $realtime,
				$signed(want.energy), $signed(energy_total));
			fails++;
		end
		if (spin_total !== want.mag) begin
			$display("%0t: spin_total exp %0d got %0d", $realtime,
				$signed(want.mag), $signed(spin_total));
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_q.delete();
			fails = 0;
			pending = 0;
			energy = '0;
			mag = '0;
			j_row = 16'd256;
			j_near = 16'd256;
			j_far = 16'd0;
			beta = 16'd51;
			torus = 1'b1;
			rows_raw = 7'd32;
			cols_raw = 7'd32;
		end else begin
			if (out_valid && !out_stall) check_word();
			if (in_valid && !in_stall) predict_word();
			if (cfg_we) begin
				case (cfg_index)
					CFG_ROW:   j_row = cfg_data;
					CFG_NEAR:  j_near = cfg_data;
					CFG_FAR:   j_far = cfg_data;
					CFG_BETA:  beta = cfg_data;
					CFG_TORUS: torus = cfg_data[0];
					CFG_ROWS:  rows_raw = cfg_data[6:0];
					CFG_COLS:  cols_raw = cfg_data[6:0];
					default: ;
				endcase
			end
			pending = result_q.size();
		end
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// testbench top of the metropolis flip engine: clock, reset, stimulus, verdict
// depends on imfe_pkg, imfe_flip_checker and the engine rtl
module tb;
	import imfe_pkg::*;

	localparam logic [1:0] KIND_SPARE = 2'd3;  // unused kind code

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        kind = KIND_LOAD;
	logic [SITE_W-1:0] site_row = '0;
	logic [SITE_W-1:0] site_col = '0;
	logic              spin_value = 1'b0;
	logic [CNT_W-1:0]  uniform_count = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              accepted;
	logic signed [DE_W-1:0] delta_energy;
	logic signed [E_W-1:0]  energy_total;
	logic signed [M_W-1:0]  spin_total;
	logic              cfg_we = 1'b0;
	logic [2:0]        cfg_index = '0;
	logic [J_W-1:0]    cfg_data = '0;

	int fails;
	int pending;

	// sites that hold a loaded spin; the store is never read before a load
	bit loaded [0:4095];
	int rows_raw = 32;
	int cols_raw = 32;
	bit torus_on = 1'b1;
	bit steady_in = 1'b0;  // stretch of back-to-back words

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ising_metropolis_flip_engine_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .site_row(site_row), .site_col(site_col),
		.spin_value(spin_value), .uniform_count(uniform_count),
		.out_valid(out_valid), .out_stall(out_stall),
		.accepted(accepted), .delta_energy(delta_energy),
		.energy_total(energy_total), .spin_total(spin_total),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	imfe_flip_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .site_row(site_row), .site_col(site_col),
		.spin_value(spin_value), .uniform_count(uniform_count),
		.out_valid(out_valid), .out_stall(out_stall),
		.accepted(accepted), .delta_energy(delta_energy),
		.energy_total(energy_total), .spin_total(spin_total),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fails(fails), .pending(pending)
	);

	// output back-pressure: short bursts, long holds and free-running stretches
	initial begin
		int seg;
		int pick;
		bit hold;
		seg = 0;
		hold = 1'b0;
		forever begin
			@(posedge clk);
			if (seg == 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 50) begin
					hold = 1'b0;
					seg = $urandom_range(1, 4);
				end else if (pick < 80) begin
					hold = 1'b1;
					seg = $urandom_range(1, 3);
				end else if (pick < 92) begin
					hold = 1'b0;
					seg = $urandom_range(30, 80);
				end else begin
					hold = 1'b1;
					seg = $urandom_range(10, 40);
				end
			end
			out_stall <= hold;
			seg--;
		end
	end

	function automatic int eff_dim(input int v);
		if (v == 0) return 1;
		if (v > 64) return 64;
		return v;
	endfunction

	function automatic int idle_cycles();
		int pick;
		if (steady_in) return 0;
		pick = $urandom_range(0, 99);
		if (pick < 55) return 0;
		if (pick < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [CNT_W-1:0] draw_count();
		if ($urandom_range(0, 4) != 0) return CNT_W'($urandom_range(1, 1000));
		return CNT_W'($urandom_range(0, 1023));
	endfunction

	// one word on the input channel; valid stays up across back-to-back words
	task automatic send_word(input logic [1:0] k, input int r, input int c,
		input logic s, input logic [CNT_W-1:0] cnt);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		site_row <= r[SITE_W-1:0];
		site_col <= c[SITE_W-1:0];
		spin_value <= s;
		uniform_count <= cnt;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (k == KIND_LOAD) loaded[r * 64 + c] = 1'b1;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// registers are only written with nothing in flight
	task automatic set_lattice(input int a, input int b, input int g, input int bt,
		input int tor, input int nr, input int nc);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= CFG_ROW;   cfg_data <= a[15:0];  @(posedge clk);
		cfg_index <= CFG_NEAR;  cfg_data <= b[15:0];  @(posedge clk);
		cfg_index <= CFG_FAR;   cfg_data <= g[15:0];  @(posedge clk);
		cfg_index <= CFG_BETA;  cfg_data <= bt[15:0]; @(posedge clk);
		cfg_index <= CFG_TORUS; cfg_data <= tor[15:0]; @(posedge clk);
		cfg_index <= CFG_ROWS;  cfg_data <= nr[15:0]; @(posedge clk);
		cfg_index <= CFG_COLS;  cfg_data <= nc[15:0]; @(posedge clk);
		cfg_we <= 1'b0;
		torus_on = tor[0];
		rows_raw = nr & 127;
		cols_raw = nc & 127;
	endtask

	task automatic fill_lattice();
		for (int r = 0; r < eff_dim(rows_raw); r++)
			for (int c = 0; c < eff_dim(cols_raw); c++)
				send_word(KIND_LOAD, r, c, $urandom_range(0, 1), '0);
	endtask

	// first site a flip at (r,c) would read before it was ever loaded
	function automatic bit flip_gap(input int r, input int c, output int mr, output int mc);
		int nr, nc, n;
		int rr [7];
		int cc [7];
		nr = eff_dim(rows_raw);
		nc = eff_dim(cols_raw);
		if (r >= nr || c >= nc) return 1'b0;
		n = 0;
		rr[n] = r; cc[n] = c; n++;
		if (torus_on) begin
			rr[n] = r; cc[n] = (c + nc - 1) % nc; n++;
			rr[n] = r; cc[n] = (c + 1) % nc; n++;
			rr[n] = (r + nr - 1) % nr; cc[n] = c; n++;
			rr[n] = (r + 1) % nr; cc[n] = c; n++;
			rr[n] = (r + 2 * nr - 2) % nr; cc[n] = c; n++;
			rr[n] = (r + 2) % nr; cc[n] = c; n++;
		end else begin
			if (c != 0) begin rr[n] = r; cc[n] = c - 1; n++; end
			if (c + 1 < nc) begin rr[n] = r; cc[n] = c + 1; n++; end
			if (r >= 1) begin rr[n] = r - 1; cc[n] = c; n++; end
			if (r + 1 < nr) begin rr[n] = r + 1; cc[n] = c; n++; end
			if (r >= 2) begin rr[n] = r - 2; cc[n] = c; n++; end
			if (r + 2 < nr) begin rr[n] = r + 2; cc[n] = c; n++; end
		end
		for (int i = 0; i < n; i++) begin
			if (!loaded[rr[i] * 64 + cc[i]]) begin
				mr = rr[i];
				mc = cc[i];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic bit walk_gap(output int mr, output int mc);
		for (int r = 0; r < eff_dim(rows_raw); r++)
			for (int c = 0; c < eff_dim(cols_raw); c++)
				if (!loaded[r * 64 + c]) begin
					mr = r;
					mc = c;
					return 1'b1;
				end
		return 1'b0;
	endfunction

	// mostly flips on loaded neighborhoods; a missing spin is loaded instead
	task automatic random_words(input int n);
		int pick, r, c, mr, mc, nr, nc;
		nr = eff_dim(rows_raw);
		nc = eff_dim(cols_raw);
		for (int i = 0; i < n; i++) begin
			if (i % 64 == 0) steady_in = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			r = $urandom_range(0, (nr > 8 ? 8 : nr) - 1);
			c = $urandom_range(0, (nc > 8 ? 8 : nc) - 1);
			if ($urandom_range(0, 3) == 0) begin
				r = $urandom_range(0, nr - 1);
				c = $urandom_range(0, nc - 1);
			end
			if (pick < 25) begin
				if ($urandom_range(0, 9) == 0) begin
					r = $urandom_range(0, 63);
					c = $urandom_range(0, 63);
				end
				send_word(KIND_LOAD, r, c, $urandom_range(0, 1), draw_count());
			end else if (pick < 85) begin
				if (flip_gap(r, c, mr, mc))
					send_word(KIND_LOAD, mr, mc, $urandom_range(0, 1), '0);
				else
					send_word(KIND_FLIP, r, c, $urandom_range(0, 1), draw_count());
			end else if (pick < 91) begin
				if (walk_gap(mr, mc))
					send_word(KIND_LOAD, mr, mc, $urandom_range(0, 1), '0);
				else
					send_word(KIND_RECALC, r, c, $urandom_range(0, 1), draw_count());
			end else if (pick < 95) begin
				send_word(KIND_SPARE, $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 1), CNT_W'($urandom_range(0, 1023)));
			end else begin
				// flip at any site of the full store range; one outside the used lattice changes nothing
				r = $urandom_range(0, 63);
				c = $urandom_range(0, 63);
				if (r < nr && c < nc && flip_gap(r, c, mr, mc))
					send_word(KIND_LOAD, mr, mc, $urandom_range(0, 1), '0);
				else
					send_word(KIND_FLIP, r, c, $urandom_range(0, 1), draw_count());
			end
		end
		steady_in = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corner loads at reset settings, spare kind, ignored flips
		send_word(KIND_LOAD, 63, 63, 1'b1, '0);
		send_word(KIND_LOAD, 63, 63, 1'b0, 10'd1023);
		send_word(KIND_SPARE, 0, 63, 1'b1, 10'd1023);
		send_word(KIND_FLIP, 40, 5, 1'b1, 10'd1);
		send_word(KIND_FLIP, 5, 40, 1'b0, 10'd1000);

		// strongest couplings, largest beta, small torus
		set_lattice(32767, -32768, -32768, 65535, 1, 4, 4);
		fill_lattice();
		send_word(KIND_RECALC, 0, 0, 1'b0, '0);
		send_word(KIND_FLIP, 0, 0, 1'b0, 10'd0);
		send_word(KIND_FLIP, 1, 2, 1'b0, 10'd1);
		send_word(KIND_FLIP, 3, 3, 1'b1, 10'd999);
		send_word(KIND_FLIP, 2, 1, 1'b1, 10'd1000);
		send_word(KIND_FLIP, 0, 3, 1'b1, 10'd1023);
		send_word(KIND_RECALC, 3, 3, 1'b1, 10'd1023);
		send_word(KIND_FLIP, 3, 0, 1'b0, 10'd500);
		random_words(120);

		// zero rows acts as one row: tiny torus where the site neighbors itself
		set_lattice(-256, 512, 128, 255, 1, 0, 1);
		send_word(KIND_LOAD, 0, 0, 1'b1, '0);
		send_word(KIND_RECALC, 0, 0, 1'b0, '0);
		random_words(60);

		// smallest nonzero beta on a 2x3 torus, then zero beta on a 3x2 torus
		set_lattice(100, -50, 25, 1, 1, 2, 3);
		fill_lattice();
		random_words(100);
		set_lattice(-300, 300, -77, 0, 1, 3, 2);
		fill_lattice();
		random_words(100);

		// open edges on 8x8 with random couplings
		set_lattice($urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(1, 1024), 0, 8, 8);
		fill_lattice();
		random_words(150);

		// largest lattice, oversized row count folds to the maximum
		set_lattice(64, 32, -16, 200, 0, 100, 64);
		random_words(150);
		set_lattice(256, 256, 0, 51, 1, 64, 127);
		random_words(120);

		// reset-like settings on 32x32 torus
		set_lattice(256, 256, 0, 51, 1, 32, 32);
		random_words(100);

		// odd-sized torus with random couplings, then open 3x2 strip with extreme couplings
		set_lattice($urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(1, 65535), 1, 5, 7);
		fill_lattice();
		random_words(150);
		set_lattice(-32768, 32767, 32767, 65535, 0, 3, 2);
		fill_lattice();
		random_words(100);

		wait_drained();
		repeat (40) @(posedge clk);
		if (fails == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/imfe_pkg.sv
src/imfe_spin_mem.sv
src/imfe_exp_unit.sv
src/ising_metropolis_flip_engine_unit.sv
dv/imfe_flip_checker.sv
dv/tb.sv
